### sv/elcu_pkg.sv
`default_nettype none
package elcu_pkg;

    localparam int VEL_W    = 32;
    localparam int CFG_W    = 31;
    localparam int MASS_W   = 31;
    localparam int ENERGY_W = 32;
    localparam int STATUS_W = 2;
    localparam int SUM_W    = 34;
    localparam int PQ_W     = 33;
    localparam int FLUX_W   = 65;
    localparam int PROD_W   = 98;
    localparam int FULL_W   = 128;
    localparam int SHIFT_DIV = 33;
    localparam int NUM_W    = FULL_W - SHIFT_DIV;
    localparam int QUO_W    = 35;
    localparam int DIV_STEP = 4;
    localparam int IN_W     = 384;
    localparam int OUT_W    = 32;
    localparam int IDX_W    = 2;

    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(65536);

    typedef enum logic [IDX_W-1:0] {
        REG_TIME_STEP   = 2'd0,
        REG_CELL_WIDTH  = 2'd1,
        REG_CELL_HEIGHT = 2'd2
    } t_reg_idx;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK        = 2'd0,
        STATUS_SATURATED = 2'd1,
        STATUS_ZERO_MASS = 2'd2
    } t_status;

    typedef struct packed {
        logic signed [ENERGY_W-1:0] energy;
        logic                       neg;
        logic                       zero;
    } t_side;

endpackage
`default_nettype wire

### sv/elcu_div.sv
`default_nettype none
module elcu_div #(
    parameter int STEP = elcu_pkg::DIV_STEP
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_adv,
    input  wire                         i_valid,
    input  wire  [elcu_pkg::NUM_W-1:0]  i_num,
    input  wire  [elcu_pkg::MASS_W-1:0] i_mass,
    input  elcu_pkg::t_side             i_side,
    output logic                        o_valid,
    output logic [elcu_pkg::QUO_W-1:0]  o_quo,
    output logic                        o_ovf,
    output elcu_pkg::t_side             o_side
);
    import elcu_pkg::*;

    localparam int STAGES = (NUM_W + STEP - 1) / STEP;
    localparam int PAD_W  = STAGES * STEP;

    logic              r_vld  [STAGES];
    logic [PAD_W-1:0]  r_num  [STAGES];
    logic [MASS_W-1:0] r_rem  [STAGES];
    logic [QUO_W-1:0]  r_quo  [STAGES];
    logic              r_ovf  [STAGES];
    logic [MASS_W-1:0] r_mass [STAGES];
    t_side             r_side [STAGES];

    logic              p_vld  [STAGES];
    logic [PAD_W-1:0]  p_num  [STAGES];
    logic [MASS_W-1:0] p_rem  [STAGES];
    logic [QUO_W-1:0]  p_quo  [STAGES];
    logic              p_ovf  [STAGES];
    logic [MASS_W-1:0] p_mass [STAGES];
    t_side             p_side [STAGES];

    logic [MASS_W-1:0] n_rem  [STAGES];
    logic [QUO_W-1:0]  n_quo  [STAGES];
    logic              n_ovf  [STAGES];

    genvar s;
    generate
        for (s = 0; s < STAGES; s++) begin : g_stage
            if (s == 0) begin : g_first
                assign p_vld[s]  = i_valid;
                assign p_num[s]  = PAD_W'(i_num);
                assign p_rem[s]  = '0;
                assign p_quo[s]  = '0;
                assign p_ovf[s]  = 1'b0;
                assign p_mass[s] = i_mass;
                assign p_side[s] = i_side;
            end else begin : g_next
                assign p_vld[s]  = r_vld[s-1];
                assign p_num[s]  = r_num[s-1];
                assign p_rem[s]  = r_rem[s-1];
                assign p_quo[s]  = r_quo[s-1];
                assign p_ovf[s]  = r_ovf[s-1];
                assign p_mass[s] = r_mass[s-1];
                assign p_side[s] = r_side[s-1];
            end

            always_comb begin
                logic [MASS_W:0] t;
                logic [MASS_W-1:0] rem;
                logic [QUO_W-1:0] quo;
                logic ovf;
                rem = p_rem[s];
                quo = p_quo[s];
                ovf = p_ovf[s];
                for (int b = 0; b < STEP; b++) begin
                    t = {rem, p_num[s][PAD_W-1-b]};
                    ovf = ovf | quo[QUO_W-1];
                    if (t >= {1'b0, p_mass[s]}) begin
                        t = t - {1'b0, p_mass[s]};
                        quo = {quo[QUO_W-2:0], 1'b1};
                    end else begin
                        quo = {quo[QUO_W-2:0], 1'b0};
                    end
                    rem = t[MASS_W-1:0];
                end
                n_rem[s] = rem;
                n_quo[s] = quo;
                n_ovf[s] = ovf;
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[s] <= 1'b0;
                end else if (i_adv) begin
                    r_vld[s] <= p_vld[s];
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_adv) begin
                    r_num[s]  <= p_num[s] << STEP;
                    r_rem[s]  <= n_rem[s];
                    r_quo[s]  <= n_quo[s];
                    r_ovf[s]  <= n_ovf[s];
                    r_mass[s] <= p_mass[s];
                    r_side[s] <= p_side[s];
                end
            end
        end
    endgenerate

    assign o_valid = r_vld[STAGES-1];
    assign o_quo   = r_quo[STAGES-1];
    assign o_ovf   = r_ovf[STAGES-1];
    assign o_side  = r_side[STAGES-1];

endmodule
`default_nettype wire

### sv/lagrangian_cell_energy_update.sv
`default_nettype none
// Lagrangian cell energy update: one cell word in and one result word out per cycle,
// new_energy = e - dt*(p+q)*((sx*dy + sy*dx)/2)/mass in signed Q16.16, saturated, status in
// tuser. The pipeline has seven stages of velocity sums and split multipliers, one stage
// per DIV_STEP quotient bits of the pipelined restoring divider, and the output register. The
// whole pipeline holds while a result waits and is not taken. The user must write registers
// through the cfg channel only while the block is idle; the block does not enforce this.
module lagrangian_cell_energy_update #(
    parameter int DIV_STEP = elcu_pkg::DIV_STEP
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_cfg_valid,
    output logic                          o_cfg_ready,
    input  wire  [elcu_pkg::IDX_W-1:0]    i_cfg_index,
    input  wire  [elcu_pkg::CFG_W-1:0]    i_cfg_data,
    input  wire                           s_axis_tvalid,
    output logic                          s_axis_tready,
    // vel_x_sw, vel_x_se, vel_x_nw, vel_x_ne, vel_y_sw, vel_y_se, vel_y_nw, vel_y_ne,
    // cell_mass, cell_energy, cell_pressure, cell_viscous_pressure
    input  wire  [elcu_pkg::IN_W-1:0]     s_axis_tdata,
    output logic                          m_axis_tvalid,
    input  wire                           m_axis_tready,
    // new_energy
    output logic [elcu_pkg::OUT_W-1:0]    m_axis_tdata,
    // status
    output logic [elcu_pkg::STATUS_W-1:0] m_axis_tuser
);
    import elcu_pkg::*;

    logic [CFG_W-1:0] r_dt, r_dx, r_dy;
    logic             adv;
    logic [7:1]       r_vld;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dt <= CFG_RESET;
            r_dx <= CFG_RESET;
            r_dy <= CFG_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_TIME_STEP:   r_dt <= i_cfg_data;
                REG_CELL_WIDTH:  r_dx <= i_cfg_data;
                REG_CELL_HEIGHT: r_dy <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic r_out_valid;
    assign adv           = !r_out_valid || m_axis_tready;
    assign s_axis_tready = adv;

    logic signed [VEL_W-1:0] xsw, xse, xnw, xne, ysw, yse, ynw, yne, pr, vp;
    assign xsw = s_axis_tdata[31:0];
    assign xse = s_axis_tdata[63:32];
    assign xnw = s_axis_tdata[95:64];
    assign xne = s_axis_tdata[127:96];
    assign ysw = s_axis_tdata[159:128];
    assign yse = s_axis_tdata[191:160];
    assign ynw = s_axis_tdata[223:192];
    assign yne = s_axis_tdata[255:224];
    assign pr  = s_axis_tdata[350:319];
    assign vp  = s_axis_tdata[382:351];

    // stage 1: sums
    logic signed [SUM_W-1:0] r1_sx, r1_sy;
    logic signed [PQ_W-1:0]  r1_pq;
    logic [MASS_W-1:0]       r1_mass;
    logic signed [ENERGY_W-1:0] r1_e;

    // stage 2: flux products
    logic [63:0]          r2_pa, r2_pb;
    logic                 r2_sa, r2_sb, r2_pqn;
    logic [PQ_W-1:0]      r2_pqm;
    logic [MASS_W-1:0]    r2_mass;
    logic signed [ENERGY_W-1:0] r2_e;

    // stage 3: signed flux
    logic [FLUX_W-1:0]    r3_s;
    logic                 r3_neg;
    logic [PQ_W-1:0]      r3_pqm;
    logic [MASS_W-1:0]    r3_mass;
    logic signed [ENERGY_W-1:0] r3_e;

    // stage 4: pressure partial products
    logic [65:0]          r4_pp0;
    logic [64:0]          r4_pp1;
    logic                 r4_neg;
    logic [MASS_W-1:0]    r4_mass;
    logic signed [ENERGY_W-1:0] r4_e;

    // stage 5
    logic [PROD_W-1:0]    r5_p;
    logic                 r5_neg;
    logic [MASS_W-1:0]    r5_mass;
    logic signed [ENERGY_W-1:0] r5_e;

    // stage 6: time step partial products
    logic [63:0]          r6_t0, r6_t1;
    logic [62:0]          r6_t2;
    logic                 r6_neg;
    logic [MASS_W-1:0]    r6_mass;
    logic signed [ENERGY_W-1:0] r6_e;

    // stage 7: dividend
    logic [NUM_W-1:0]     r7_num;
    logic                 r7_neg;
    logic [MASS_W-1:0]    r7_mass;
    logic signed [ENERGY_W-1:0] r7_e;

    logic [SUM_W-1:0]  w_sxm, w_sym;
    logic [64:0]       w_pa, w_pb;
    logic [FLUX_W-1:0] w_s;
    logic              w_ss;
    logic [65:0]       w_pp0;
    logic [64:0]       w_pp1;
    logic [63:0]       w_t0, w_t1;
    logic [62:0]       w_t2;
    logic [FULL_W-1:0] w_n;

    assign w_sxm = r1_sx[SUM_W-1] ? SUM_W'(-r1_sx) : SUM_W'(r1_sx);
    assign w_sym = r1_sy[SUM_W-1] ? SUM_W'(-r1_sy) : SUM_W'(r1_sy);
    assign w_pa  = w_sxm * r_dy;
    assign w_pb  = w_sym * r_dx;

    always_comb begin
        if (r2_sa == r2_sb) begin
            w_s  = {1'b0, r2_pa} + {1'b0, r2_pb};
            w_ss = r2_sa;
        end else if (r2_pa >= r2_pb) begin
            w_s  = {1'b0, r2_pa - r2_pb};
            w_ss = r2_sa;
        end else begin
            w_s  = {1'b0, r2_pb - r2_pa};
            w_ss = r2_sb;
        end
    end

    assign w_pp0 = r3_s[32:0] * r3_pqm;
    assign w_pp1 = r3_s[64:33] * r3_pqm;
    assign w_t0  = r5_p[32:0] * r_dt;
    assign w_t1  = r5_p[65:33] * r_dt;
    assign w_t2  = r5_p[97:66] * r_dt;
    assign w_n   = FULL_W'(r6_t0) + (FULL_W'(r6_t1) << 33) + (FULL_W'(r6_t2) << 66);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[6:1], s_axis_tvalid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_sx   <= SUM_W'(xse) + SUM_W'(xne) - SUM_W'(xsw) - SUM_W'(xnw);
            r1_sy   <= SUM_W'(ynw) + SUM_W'(yne) - SUM_W'(ysw) - SUM_W'(yse);
            r1_pq   <= PQ_W'(pr) + PQ_W'(vp);
            r1_mass <= s_axis_tdata[286:256];
            r1_e    <= s_axis_tdata[318:287];

            r2_pa   <= w_pa[63:0];
            r2_pb   <= w_pb[63:0];
            r2_sa   <= r1_sx[SUM_W-1];
            r2_sb   <= r1_sy[SUM_W-1];
            r2_pqn  <= r1_pq[PQ_W-1];
            r2_pqm  <= r1_pq[PQ_W-1] ? PQ_W'(-r1_pq) : PQ_W'(r1_pq);
            r2_mass <= r1_mass;
            r2_e    <= r1_e;

            r3_s    <= w_s;
            r3_neg  <= w_ss ^ r2_pqn;
            r3_pqm  <= r2_pqm;
            r3_mass <= r2_mass;
            r3_e    <= r2_e;

            r4_pp0  <= w_pp0;
            r4_pp1  <= w_pp1;
            r4_neg  <= r3_neg;
            r4_mass <= r3_mass;
            r4_e    <= r3_e;

            r5_p    <= PROD_W'(r4_pp0) + (PROD_W'(r4_pp1) << 33);
            r5_neg  <= r4_neg;
            r5_mass <= r4_mass;
            r5_e    <= r4_e;

            r6_t0   <= w_t0;
            r6_t1   <= w_t1;
            r6_t2   <= w_t2;
            r6_neg  <= r5_neg;
            r6_mass <= r5_mass;
            r6_e    <= r5_e;

            r7_num  <= w_n[FULL_W-1:SHIFT_DIV];
            r7_neg  <= r6_neg;
            r7_mass <= r6_mass;
            r7_e    <= r6_e;
        end
    end

    t_side             w_side_in, w_side_out;
    logic              w_dvld, w_ovf;
    logic [QUO_W-1:0]  w_quo;

    assign w_side_in = '{energy: r7_e, neg: r7_neg, zero: (r7_mass == '0)};

    elcu_div #(
        .STEP (DIV_STEP)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (r_vld[7]),
        .i_num   (r7_num),
        .i_mass  (r7_mass),
        .i_side  (w_side_in),
        .o_valid (w_dvld),
        .o_quo   (w_quo),
        .o_ovf   (w_ovf),
        .o_side  (w_side_out)
    );

    logic signed [35:0] w_e36, w_q36, w_res;
    logic               w_big;
    logic [OUT_W-1:0]   n_energy;
    t_status            n_status;

    assign w_e36 = 36'(w_side_out.energy);
    assign w_q36 = {2'b00, w_quo[QUO_W-2:0]};
    assign w_res = w_side_out.neg ? w_e36 + w_q36 : w_e36 - w_q36;
    assign w_big = w_ovf | w_quo[QUO_W-1];

    always_comb begin
        priority if (w_side_out.zero) begin
            n_energy = w_side_out.energy;
            n_status = STATUS_ZERO_MASS;
        end else if ((w_big && w_side_out.neg) || (!w_big && w_res > 36'sh07FFFFFFF)) begin
            n_energy = 32'h7FFF_FFFF;
            n_status = STATUS_SATURATED;
        end else if (w_big || w_res < -36'sh080000000) begin
            n_energy = 32'h8000_0000;
            n_status = STATUS_SATURATED;
        end else begin
            n_energy = w_res[OUT_W-1:0];
            n_status = STATUS_OK;
        end
    end

    logic [OUT_W-1:0]    r_out_energy;
    logic [STATUS_W-1:0] r_out_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= w_dvld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_energy <= n_energy;
            r_out_status <= n_status;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_energy;
    assign m_axis_tuser  = r_out_status;

endmodule
`default_nettype wire

### sv/elcu_checker.sv
`default_nettype none
module elcu_checker (
    input wire                           i_clk,
    input wire                           i_rst_n,
    input wire                           s_axis_tvalid,
    input wire                           s_axis_tready,
    input wire                           m_axis_tvalid,
    input wire                           m_axis_tready,
    input wire [elcu_pkg::OUT_W-1:0]     m_axis_tdata,
    input wire [elcu_pkg::STATUS_W-1:0]  m_axis_tuser
);
    import elcu_pkg::*;

    a_hold_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
        else $error("result word changed while stalled");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tuser == STATUS_OK || m_axis_tuser == STATUS_SATURATED
            || m_axis_tuser == STATUS_ZERO_MASS)
        else $error("undefined status code");

    a_sat_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == STATUS_SATURATED
            |-> m_axis_tdata == 32'h7FFF_FFFF || m_axis_tdata == 32'h8000_0000)
        else $error("saturated word not at a bound");

    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result word after reset");

endmodule

bind lagrangian_cell_energy_update elcu_checker u_elcu_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire

### tb/lagrangian_cell_energy_update_tb.sv
`timescale 1ns / 100ps
`default_nettype none
module lagrangian_cell_energy_update_tb;
    import elcu_pkg::*;

    localparam int        PHASE_ITEMS = 260;
    localparam int        DRAIN_CYCLES = 48;
    localparam longint    CYCLE_LIMIT = 400000;
    localparam logic [IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam logic [31:0] S_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] S_MIN = 32'h8000_0000;
    localparam logic [30:0] U_MAX = 31'h7FFF_FFFF;
    localparam logic [30:0] ONE_Q = 31'd65536;

    typedef struct packed {
        logic [31:0] x_sw, x_se, x_nw, x_ne;
        logic [31:0] y_sw, y_se, y_nw, y_ne;
        logic [30:0] mass;
        logic [31:0] energy, pressure, visc;
    } t_cell;

    typedef struct packed {
        logic [31:0] energy;
        t_status     status;
    } t_update;

    typedef struct packed {
        t_cell   stim;
        logic    typed;
        t_update update;
    } t_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic [IDX_W-1:0]      i_cfg_index = '0;
    logic [CFG_W-1:0]      i_cfg_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic [IN_W-1:0]       s_axis_tdata = '0;
    logic                  m_axis_tready = 1'b0;
    logic                  o_cfg_ready;
    logic                  s_axis_tready;
    logic                  m_axis_tvalid;
    logic [OUT_W-1:0]      m_axis_tdata;
    logic [STATUS_W-1:0]   m_axis_tuser;

    lagrangian_cell_energy_update dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    logic [30:0] dt_reg = ONE_Q, dx_reg = ONE_Q, dy_reg = ONE_Q;
    t_update     pending_updates[$];
    int          fail_count = 0;
    int          checked_count = 0;
    int          saturated_count = 0;
    int          zero_mass_count = 0;
    int          sent_count = 0;
    longint      cycle_count = 0;
    logic        gaps_on = 1'b1;

    function automatic logic [IN_W-1:0] pack_cell(t_cell c);
        return {1'b0, c.visc, c.pressure, c.energy, c.mass,
                c.y_ne, c.y_nw, c.y_se, c.y_sw, c.x_ne, c.x_nw, c.x_se, c.x_sw};
    endfunction

    function automatic t_update compute_energy(t_cell c);
        longint      sx, sy, pq, e, res;
        logic [127:0] pa, pb, lo, num, rem, quo;
        logic        ss, neg;
        t_update     u;
        if (c.mass == 0) begin
            u.energy = c.energy;
            u.status = STATUS_ZERO_MASS;
            return u;
        end
        sx = longint'($signed(c.x_se)) + longint'($signed(c.x_ne))
           - longint'($signed(c.x_sw)) - longint'($signed(c.x_nw));
        sy = longint'($signed(c.y_nw)) + longint'($signed(c.y_ne))
           - longint'($signed(c.y_sw)) - longint'($signed(c.y_se));
        pq = longint'($signed(c.pressure)) + longint'($signed(c.visc));
        e  = longint'($signed(c.energy));
        pa = 128'(sx < 0 ? -sx : sx) * 128'(dy_reg);
        pb = 128'(sy < 0 ? -sy : sy) * 128'(dx_reg);
        if ((sx < 0) == (sy < 0)) begin
            lo = pa + pb;
            ss = sx < 0;
        end else if (pa >= pb) begin
            lo = pa - pb;
            ss = sx < 0;
        end else begin
            lo = pb - pa;
            ss = sy < 0;
        end
        num = lo * 128'(pq < 0 ? -pq : pq) * 128'(dt_reg);
        neg = ss != (pq < 0);
        rem = '0;
        quo = '0;
        for (int k = 127; k >= 33; k--) begin
            logic qb;
            qb = 1'b0;
            rem = {rem[126:0], num[k]};
            if (rem >= 128'(c.mass)) begin
                rem = rem - 128'(c.mass);
                qb = 1'b1;
            end
            if (quo >= (128'd1 << 36)) quo = 128'd1 << 36;
            else quo = {quo[126:0], qb};
        end
        res = neg ? e + longint'(quo) : e - longint'(quo);
        if (res > 64'sd2147483647) begin
            u.energy = S_MAX;
            u.status = STATUS_SATURATED;
        end else if (res < -64'sd2147483648) begin
            u.energy = S_MIN;
            u.status = STATUS_SATURATED;
        end else begin
            u.energy = res[31:0];
            u.status = STATUS_OK;
        end
        return u;
    endfunction

    function automatic logic [31:0] pick_extreme();
        case ($urandom_range(0, 5))
            0: return S_MAX;
            1: return S_MIN;
            2: return 32'h0;
            3: return 32'hFFFF_FFFF;
            4: return 32'h0001_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] small_value(int span);
        return 32'($signed($urandom_range(0, 2 * span)) - span);
    endfunction

    function automatic t_cell random_cell();
        t_cell c;
        int    mode;
        mode = $urandom_range(0, 9);
        if (mode < 5) begin
            c.x_sw = small_value(1 << 19); c.x_se = small_value(1 << 19);
            c.x_nw = small_value(1 << 19); c.x_ne = small_value(1 << 19);
            c.y_sw = small_value(1 << 19); c.y_se = small_value(1 << 19);
            c.y_nw = small_value(1 << 19); c.y_ne = small_value(1 << 19);
            c.mass = 31'($urandom_range(1, 1 << 24));
            c.energy = small_value(1 << 26);
            c.pressure = small_value(1 << 22);
            c.visc = small_value(1 << 20);
        end else if (mode < 8) begin
            c = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom, 31'($urandom), $urandom, $urandom, $urandom};
        end else begin
            c.x_sw = pick_extreme(); c.x_se = pick_extreme();
            c.x_nw = pick_extreme(); c.x_ne = pick_extreme();
            c.y_sw = pick_extreme(); c.y_se = pick_extreme();
            c.y_nw = pick_extreme(); c.y_ne = pick_extreme();
            c.mass = 31'(pick_extreme());
            c.energy = pick_extreme();
            c.pressure = pick_extreme();
            c.visc = pick_extreme();
        end
        if ($urandom_range(0, 19) == 0) c.mass = '0;
        return c;
    endfunction

    function automatic int gap_length();
        if (!gaps_on || $urandom_range(0, 99) >= 20) return 0;
        return $urandom_range(1, 2);
    endfunction

    task automatic send_cell(t_cell c, logic typed, t_update known);
        int gap;
        gap = gap_length();
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata = pack_cell(c);
        do @(posedge i_clk); while (!s_axis_tready);
        pending_updates.push_back(typed ? known : compute_energy(c));
        sent_count++;
    endtask

    task automatic write_reg(logic [IDX_W-1:0] idx, logic [30:0] value);
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = value;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_TIME_STEP:   dt_reg = value;
            REG_CELL_WIDTH:  dx_reg = value;
            REG_CELL_HEIGHT: dy_reg = value;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (pending_updates.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    always @(negedge i_clk) begin
        m_axis_tready <= !gaps_on || ($urandom_range(0, 99) >= 20);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[lagrangian_cell_energy_update] ERROR");
            $finish;
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_updates.size() == 0) begin
                $error("unexpected word: new_energy %h status %0d", m_axis_tdata, m_axis_tuser);
                fail_count++;
            end else begin
                t_update want;
                want = pending_updates.pop_front();
                if (m_axis_tdata !== want.energy) begin
                    $error("new_energy: expected %h, got %h", want.energy, m_axis_tdata);
                    fail_count++;
                end
                if (m_axis_tuser !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_axis_tuser);
                    fail_count++;
                end
                checked_count++;
                if (want.status == STATUS_SATURATED) saturated_count++;
                if (want.status == STATUS_ZERO_MASS) zero_mass_count++;
            end
        end
    end

    t_row directed_rows[$];

    initial begin
        t_cell   c;
        t_update none;
        logic [30:0] settings[6][3];

        none = '{energy: '0, status: STATUS_OK};
        settings = '{'{U_MAX, U_MAX, U_MAX}, '{31'd1, 31'd1, 31'd1},
                     '{31'h8000, 31'h20000, 31'h4000}, '{ONE_Q, ONE_Q, ONE_Q},
                     '{31'($urandom_range(1, 1 << 20)), 31'($urandom_range(1, 1 << 20)),
                       31'($urandom_range(1, 1 << 20))},
                     '{31'($urandom) | 31'd1, 31'($urandom) | 31'd1, 31'($urandom) | 31'd1}};

        c = '0;
        directed_rows.push_back('{c, 1'b1, '{32'h0, STATUS_ZERO_MASS}});
        c.energy = 32'h1234_5678;
        directed_rows.push_back('{c, 1'b1, '{32'h1234_5678, STATUS_ZERO_MASS}});
        c.mass = U_MAX;
        directed_rows.push_back('{c, 1'b1, '{32'h1234_5678, STATUS_OK}});
        c = '{S_MIN, S_MAX, S_MIN, S_MAX, S_MIN, S_MIN, S_MAX, S_MAX,
              31'd1, 32'h0, S_MAX, S_MAX};
        directed_rows.push_back('{c, 1'b1, '{S_MIN, STATUS_SATURATED}});
        c.pressure = S_MIN;
        c.visc = S_MIN;
        directed_rows.push_back('{c, 1'b1, '{S_MAX, STATUS_SATURATED}});
        c.mass = '0;
        c.energy = S_MIN;
        directed_rows.push_back('{c, 1'b1, '{S_MIN, STATUS_ZERO_MASS}});
        c = '{S_MIN, S_MAX, S_MIN, S_MAX, S_MIN, S_MIN, S_MAX, S_MAX,
              U_MAX, S_MAX, S_MAX, S_MAX};
        directed_rows.push_back('{c, 1'b0, none});
        c = '{32'h0, 32'h10000, 32'h0, 32'h10000, 32'h0, 32'h0, 32'h10000, 32'h10000,
              ONE_Q, 32'h50000, 32'h10000, 32'h8000};
        directed_rows.push_back('{c, 1'b0, none});
        c.pressure = 32'hFFFF_0000;
        directed_rows.push_back('{c, 1'b0, none});
        c = '{32'h10000, 32'h0, 32'h10000, 32'h0, 32'h0, 32'h10000, 32'h0, 32'h0,
              31'd3, 32'hFFFF_FFFF, 32'h7, 32'h0};
        directed_rows.push_back('{c, 1'b0, none});
        c = '{S_MAX, S_MAX, S_MAX, S_MAX, S_MIN, S_MIN, S_MIN, S_MIN,
              31'd1, S_MAX, S_MAX, S_MIN};
        directed_rows.push_back('{c, 1'b0, none});
        c = '{32'hFFFF_FFFF, 32'h1, 32'h0, 32'h0, 32'h0, 32'h1, 32'hFFFF_FFFF, 32'h0,
              31'd1, S_MAX, S_MIN, 32'hFFFF_FFFF};
        directed_rows.push_back('{c, 1'b0, none});

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed_rows[n])
            send_cell(directed_rows[n].stim, directed_rows[n].typed, directed_rows[n].update);
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            write_reg(REG_TIME_STEP, settings[ph][0]);
            write_reg(REG_CELL_WIDTH, settings[ph][1]);
            write_reg(REG_CELL_HEIGHT, settings[ph][2]);
            if (ph == 2) write_reg(REG_UNUSED, 31'h0);
            gaps_on = (ph != 3);
            for (int n = 0; n < PHASE_ITEMS; n++) send_cell(random_cell(), 1'b0, none);
            drain();
        end
        gaps_on = 1'b1;

        $display("Sent %0d cells over 7 register settings; checked %0d results,",
                 sent_count, checked_count);
        $display("%0d saturated and %0d with zero mass.", saturated_count, zero_mass_count);
        if (fail_count == 0 && pending_updates.size() == 0) begin
            $display("[lagrangian_cell_energy_update] OK");
        end else begin
            $display("[lagrangian_cell_energy_update] ERROR");
        end
        $finish;
    end

endmodule
`default_nettype wire

### filelist.f
sv/elcu_pkg.sv
sv/elcu_div.sv
sv/lagrangian_cell_energy_update.sv
sv/elcu_checker.sv
tb/lagrangian_cell_energy_update_tb.sv
